// File: rtl/core/ddo_pkg.sv
// Shared types and constants for the differential-drive odometry unit.
package ddo_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CORDIC,
    ST_PROJ,
    ST_DONE
  } state_t;

  localparam logic [31:0] MPC_RESET = 32'd12240141;
  localparam logic [31:0] APM_RESET = 32'd2196890000;
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  localparam logic [1:0] REG_MPC = 2'd0;
  localparam logic [1:0] REG_APM = 2'd1;
  localparam logic [1:0] REG_INV = 2'd2;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;
      5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;
      5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;
      5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;
      5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;
      5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/core/ddo_if.sv
// Valid/ready channel interfaces for input counts and odometry results.
interface ddo_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] left_count;
  logic [31:0] right_count;
  modport source (output valid, left_count, right_count, input ready);
  modport sink (input valid, left_count, right_count, output ready);
endinterface

interface ddo_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] heading_angle;
  logic [31:0] step_distance;
  logic [31:0] step_turn;
  modport source (output valid, pos_x, pos_y, heading_angle, step_distance, step_turn,
                  input ready);
  modport sink (input valid, pos_x, pos_y, heading_angle, step_distance, step_turn,
                output ready);
endinterface

// File: rtl/core/ddo_mul.sv
// Serial signed multiplier: one 16-bit slice of operand b per cycle.
module ddo_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [65:0] a,
  input  logic        [63:0] b,
  input  logic        [2:0]  slices,
  output logic               done,
  output logic signed [65:0] prod
);
  logic signed [65:0] acc_r, acc_nxt;
  logic        [63:0] b_r, b_nxt;
  logic signed [65:0] a_r, a_nxt;
  logic        [2:0]  cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic signed [82:0] part;

  // partial product of the low slice, weighted into a shifting accumulator
  assign part = a_r * $signed({1'b0, b_r[15:0]});

  always_comb begin
    acc_nxt = acc_r;
    b_nxt = b_r;
    a_nxt = a_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      acc_nxt = '0;
      a_nxt = a;
      b_nxt = b;
      cnt_nxt = slices;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + part[65:0];
      a_nxt = a_r <<< 16;
      b_nxt = b_r >> 16;
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign done = busy_r && (cnt_r == 3'd1);
  assign prod = acc_r + part[65:0];
endmodule

// File: rtl/core/diff_drive_odometry_unit.sv
// Differential-drive odometry: serial multiplies plus an iterative CORDIC.
//
//  channel | dir | beat contents
//  in_     | in  | left_count, right_count
//  out_    | out | pos_x, pos_y, heading_angle, step_distance, step_turn
//  cfg_    | in  | write enable, index, 32-bit data
//
// Without output stalls, a beat passes through the accept cycle, three serial
// multiplies through one 66x16 multiplier, one CORDIC iteration per cycle, two
// projection multiplies and the result state.
// in_ready is high only while idle; the result beat holds until out_ready.
// Synchronous reset restores the state, configuration, position, heading and last-count registers.
module diff_drive_odometry_unit #(
  parameter int CORDIC_STEPS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ddo_in_if.sink      in_ch,
  ddo_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int SH = 33 - FRAC_BITS;

  ddo_pkg::state_t st_r, st_nxt;
  logic [31:0] mpc_r, apm_r;
  logic        inv_r;
  logic [31:0] last_l_r, last_r_r, head_r, turn_r;
  logic signed [31:0] ax_r, ay_r, dist_r;
  logic [31:0] dl_r, dr_r;
  logic [1:0]  mstep_r;
  logic [4:0]  it_r;
  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic        flip_r;
  logic [63:0] k_r;
  logic        mstart, mdone;
  logic signed [65:0] ma, mprod;
  logic [63:0] mb;
  logic [2:0]  mslices;

  ddo_mul u_mul (.clk, .rst_n, .start(mstart), .a(ma), .b(mb), .slices(mslices),
                 .done(mdone), .prod(mprod));

  logic [31:0] left_in;
  logic signed [65:0] dd;
  logic signed [65:0] mean_sh;
  logic signed [65:0] dxy;
  logic signed [33:0] xs, ys;
  logic signed [33:0] cx_step, cy_step;
  logic signed [32:0] cz_step, atan_v;

  assign left_in = inv_r ? (32'd0 - in_ch.left_count) : in_ch.left_count;
  // the count difference needs 33 bits before it scales the turn
  assign dd = {{34{dr_r[31]}}, dr_r} - {{34{dl_r[31]}}, dl_r};
  assign mean_sh = mprod >>> SH;
  // projection products fit in 64 bits; drop the bits above
  assign dxy = $signed({{2{mprod[63]}}, mprod[63:0]}) >>> 30;
  assign xs = cx_r >>> it_r;
  assign ys = cy_r >>> it_r;
  assign atan_v = $signed({1'b0, ddo_pkg::atan_lut(it_r)});
  assign cx_step = cz_r[32] ? (cx_r + ys) : (cx_r - ys);
  assign cy_step = cz_r[32] ? (cy_r - xs) : (cy_r + xs);
  assign cz_step = cz_r[32] ? (cz_r + atan_v) : (cz_r - atan_v);

  // multiply schedule: 0 mpc*apm, 1 dd*k, 2 (dl+dr)*mpc; projection 0 dist*cos, 1 dist*sin
  always_comb begin
    ma = '0;
    mb = '0;
    mslices = 3'd2;
    case (st_r)
      ddo_pkg::ST_MUL: begin
        case (mstep_r)
          2'd0: begin
            ma = {34'd0, mpc_r};
            mb = {32'd0, apm_r};
          end
          2'd1: begin
            ma = dd;
            mb = k_r;
            mslices = 3'd4;
          end
          default: begin
            ma = {{34{dl_r[31]}}, dl_r} + {{34{dr_r[31]}}, dr_r};
            mb = {32'd0, mpc_r};
          end
        endcase
      end
      ddo_pkg::ST_PROJ: begin
        ma = {{34{dist_r[31]}}, dist_r};
        if (mstep_r == 2'd0) mb = {{30{cx_r[33]}}, cx_r};
        else mb = {{30{cy_r[33]}}, cy_r};
        mslices = 3'd4;
      end
      default: ;
    endcase
  end

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fffffff;
    if (v < -66'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  logic started_r;
  logic signed [65:0] addend;
  logic signed [65:0] tot;
  assign addend = (mstep_r == 2'd0) ? {{34{ax_r[31]}}, ax_r} : {{34{ay_r[31]}}, ay_r};
  assign tot = addend + dxy;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ddo_pkg::ST_IDLE: if (in_ch.valid) st_nxt = ddo_pkg::ST_MUL;
      ddo_pkg::ST_MUL: if (mdone && mstep_r == 2'd2) st_nxt = ddo_pkg::ST_CORDIC;
      ddo_pkg::ST_CORDIC:
        if (it_r == 5'(CORDIC_STEPS - 1)) st_nxt = ddo_pkg::ST_PROJ;
      ddo_pkg::ST_PROJ: if (mdone && mstep_r == 2'd1) st_nxt = ddo_pkg::ST_DONE;
      ddo_pkg::ST_DONE: if (out_ch.ready) st_nxt = ddo_pkg::ST_IDLE;
      default: st_nxt = ddo_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ddo_pkg::ST_IDLE;
      mpc_r <= ddo_pkg::MPC_RESET;
      apm_r <= ddo_pkg::APM_RESET;
      inv_r <= 1'b1;
      last_l_r <= '0;
      last_r_r <= '0;
      ax_r <= '0;
      ay_r <= '0;
      head_r <= '0;
      mstep_r <= '0;
      it_r <= '0;
      started_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        case (cfg_index)
          ddo_pkg::REG_MPC: mpc_r <= cfg_data;
          ddo_pkg::REG_APM: apm_r <= cfg_data;
          ddo_pkg::REG_INV: inv_r <= cfg_data[0];
          default: ;
        endcase
      end
      // a multiply is in flight from its start until its done cycle
      if (mstart) started_r <= 1'b1;
      else if (mdone) started_r <= 1'b0;
      case (st_r)
        ddo_pkg::ST_IDLE: begin
          mstep_r <= '0;
          if (in_ch.valid) begin
            dl_r <= left_in - last_l_r;
            dr_r <= in_ch.right_count - last_r_r;
            last_l_r <= left_in;
            last_r_r <= in_ch.right_count;
          end
        end
        ddo_pkg::ST_MUL: begin
          if (mdone) begin
            case (mstep_r)
              2'd0: k_r <= mprod[63:0];
              2'd1: turn_r <= mprod[63:32];
              default: dist_r <= sat32(mean_sh);
            endcase
            mstep_r <= (mstep_r == 2'd2) ? 2'd0 : mstep_r + 2'd1;
          end
          if (mdone && mstep_r == 2'd2) begin
            it_r <= '0;
            flip_r <= head_r[31] ^ head_r[30];
            cz_r <= {head_r[31] ^ head_r[30] ^ head_r[31],
                     head_r[31] ^ head_r[30] ^ head_r[31], head_r[30:0]};
            cx_r <= {2'b00, ddo_pkg::CORDIC_GAIN_Q30};
            cy_r <= '0;
          end
        end
        ddo_pkg::ST_CORDIC: begin
          it_r <= it_r + 5'd1;
          cz_r <= cz_step;
          // negate on the last iteration when the heading was rotated by pi
          if (it_r == 5'(CORDIC_STEPS - 1) && flip_r) begin
            cx_r <= -cx_step;
            cy_r <= -cy_step;
          end else begin
            cx_r <= cx_step;
            cy_r <= cy_step;
          end
        end
        ddo_pkg::ST_PROJ: begin
          if (mdone) begin
            if (mstep_r == 2'd0) ax_r <= sat32(tot);
            else begin
              ay_r <= sat32(tot);
              head_r <= head_r + turn_r;
            end
            mstep_r <= mstep_r + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // issue a multiply whenever a step needs one and none is in flight
  assign mstart = (st_r == ddo_pkg::ST_MUL || st_r == ddo_pkg::ST_PROJ) && !started_r;

  assign in_ch.ready = (st_r == ddo_pkg::ST_IDLE);
  assign out_ch.valid = (st_r == ddo_pkg::ST_DONE);
  assign out_ch.pos_x = ax_r;
  assign out_ch.pos_y = ay_r;
  assign out_ch.heading_angle = head_r;
  assign out_ch.step_distance = dist_r;
  assign out_ch.step_turn = turn_r;
endmodule
